/* src/ostp_pkg.sv */
`timescale 1ns / 1ps

package ostp_pkg;

   // Field widths
   localparam int unsigned ADDR_W  = 24;
   localparam int unsigned DATA_W  = 32;
   localparam int unsigned MASK_W  = 4;
   localparam int unsigned IRQ_W   = 4;
   localparam int unsigned MODE_W  = 2;
   localparam int unsigned COUNT_W = 31;
   localparam int unsigned CSR_IDX_W = 2;

   // Request kinds
   localparam logic [MODE_W-1:0] REQ_TICK  = 2'd0;
   localparam logic [MODE_W-1:0] REQ_READ  = 2'd1;
   localparam logic [MODE_W-1:0] REQ_WRITE = 2'd2;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CTRL_ADDR = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IRQ_LEVEL = 2'd1;

   // Reset values of the configuration registers
   localparam logic [ADDR_W-1:0] CTRL_ADDR_RESET = 24'h000000;
   localparam logic [IRQ_W-1:0]  IRQ_LEVEL_RESET = 4'd10;

   typedef enum logic [1:0] {
      TMR_DISABLED     = 2'd0,
      TMR_COUNTING     = 2'd1,
      TMR_INTERRUPTING = 2'd2
   } timer_state_type;

   typedef struct packed {
      logic              is_bus_response;
      logic [DATA_W-1:0] read_data;
      logic [IRQ_W-1:0]  interrupt_out;
   } rsp_type;

endpackage

/* src/ostp_core.sv */
`timescale 1ns / 1ps

module ostp_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   input  logic [ostp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ostp_pkg::DATA_W-1:0]          csr_write_data,
   input  logic                                 req_accept,
   input  logic [ostp_pkg::MODE_W-1:0]          req_mode,
   input  logic [ostp_pkg::ADDR_W-1:0]          req_address,
   input  logic [ostp_pkg::DATA_W-1:0]          req_write_data,
   input  logic [ostp_pkg::MASK_W-1:0]          req_write_strobe,
   output ostp_pkg::rsp_type                    rsp_data
);

   logic [ostp_pkg::ADDR_W-1:0]  ctrl_addr_ff, ctrl_addr_in;
   logic [ostp_pkg::IRQ_W-1:0]   irq_level_ff, irq_level_in;
   logic [ostp_pkg::DATA_W-1:0]  control_ff, control_in;
   ostp_pkg::timer_state_type    state_ff, state_in;
   logic [ostp_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [ostp_pkg::COUNT_W-1:0] limit_ff, limit_in;
   logic [ostp_pkg::IRQ_W-1:0]   irq_ff, irq_in;

   logic [ostp_pkg::DATA_W-1:0]  byte_keep;
   logic [ostp_pkg::DATA_W-1:0]  merged;
   logic [ostp_pkg::COUNT_W-1:0] count_inc;
   logic                         write_hit;

   // Configuration registers
   always_comb begin
      ctrl_addr_in = ctrl_addr_ff;
      irq_level_in = irq_level_ff;
      if (csr_valid) begin
         case (csr_index)
            ostp_pkg::CSR_CTRL_ADDR: ctrl_addr_in = csr_write_data[ostp_pkg::ADDR_W-1:0];
            ostp_pkg::CSR_IRQ_LEVEL: irq_level_in = csr_write_data[ostp_pkg::IRQ_W-1:0];
            default: ;
         endcase
      end
   end

   // Expand the write strobes and merge write data into the control word
   always_comb begin
      for (int i = 0; i < ostp_pkg::MASK_W; i++) begin
         byte_keep[i*8 +: 8] = {8{req_write_strobe[i]}};
      end
      merged = (control_ff & ~byte_keep) | (req_write_data & byte_keep);
   end

   assign count_inc = count_ff + 1'b1;
   assign write_hit = (req_address == ctrl_addr_ff);

   // Timer next state and result of the accepted request
   always_comb begin
      control_in = control_ff;
      state_in   = state_ff;
      count_in   = count_ff;
      limit_in   = limit_ff;
      irq_in     = irq_ff;
      rsp_data.is_bus_response = 1'b0;
      rsp_data.read_data       = '0;
      if (req_accept) begin
         case (req_mode)
            ostp_pkg::REQ_TICK: begin
               if (state_ff == ostp_pkg::TMR_COUNTING) begin
                  count_in = count_inc;
                  if (count_inc >= limit_ff) begin
                     state_in = ostp_pkg::TMR_INTERRUPTING;
                     irq_in   = irq_level_ff;
                  end
               end
            end
            ostp_pkg::REQ_READ: begin
               rsp_data.is_bus_response = 1'b1;
               rsp_data.read_data       = control_ff;
            end
            ostp_pkg::REQ_WRITE: begin
               rsp_data.is_bus_response = 1'b1;
               if (write_hit) begin
                  control_in = merged;
                  if (!merged[0]) begin
                     state_in = ostp_pkg::TMR_DISABLED;
                     irq_in   = '0;
                     count_in = '0;
                     limit_in = '0;
                  end else if (state_ff == ostp_pkg::TMR_DISABLED) begin
                     state_in = ostp_pkg::TMR_COUNTING;
                     irq_in   = '0;
                     count_in = '0;
                     limit_in = merged[ostp_pkg::DATA_W-1:1];
                  end
               end
            end
            default: ;
         endcase
      end
      rsp_data.interrupt_out = irq_in;
   end

   // Hold timer and configuration state
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_addr_ff <= ostp_pkg::CTRL_ADDR_RESET;
         irq_level_ff <= ostp_pkg::IRQ_LEVEL_RESET;
         control_ff   <= '0;
         state_ff     <= ostp_pkg::TMR_DISABLED;
         count_ff     <= '0;
         limit_ff     <= '0;
         irq_ff       <= '0;
      end else begin
         ctrl_addr_ff <= ctrl_addr_in;
         irq_level_ff <= irq_level_in;
         control_ff   <= control_in;
         state_ff     <= state_in;
         count_ff     <= count_in;
         limit_ff     <= limit_in;
         irq_ff       <= irq_in;
      end
   end

endmodule

/* src/ostp_rsp_buf.sv */
`timescale 1ns / 1ps

module ostp_rsp_buf (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_stall,
   input  ostp_pkg::rsp_type in_data,
   output logic              out_valid,
   input  logic              out_stall,
   output ostp_pkg::rsp_type out_data
);

   logic              out_valid_ff, out_valid_in;
   logic              skid_valid_ff, skid_valid_in;
   ostp_pkg::rsp_type out_data_ff, out_data_in;
   ostp_pkg::rsp_type skid_data_ff, skid_data_in;
   logic              accept;
   logic              out_free;

   assign in_stall  = skid_valid_ff;
   assign accept    = in_valid & ~skid_valid_ff;
   assign out_free  = ~out_valid_ff | ~out_stall;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   // Advance the output register, park a new response in the skid stage on stall
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = accept;
            out_data_in  = in_data;
         end
      end else if (accept) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

/* src/one_shot_timer_peripheral.sv */
`timescale 1ns / 1ps

// One-shot interrupt timer behind a single control register.
// Request channel (req_*): each request is a tick, a bus read or a bus write
// with byte write strobes; it is taken when req_valid is high and req_stall is low.
// Response channel (rsp_*): exactly one response per request, in order, taken
// when rsp_valid is high and rsp_stall is low. Bus accesses set
// rsp_is_bus_response; reads return the control word, everything else zero.
// rsp_interrupt_out is the interrupt line after the request took effect.
// Configuration channel (csr_*): index 0 sets the control address, index 1
// the interrupt level; csr_ready is always high, other indexes are ignored.
// The response is registered in the output stage (or the skid stage on a stall).
// Throughput: one request per cycle while req_stall is low; the timer update (one
// 31-bit increment and compare plus a masked word write) completes in the accepting cycle.
// When the receiver stalls, one more response is parked in a skid stage and
// req_stall rises in the following cycle until the skid stage drains.
// Reset clears the timer (disabled, count, limit and interrupt zero), the
// control word, and both response stages; the control address resets to 0
// and the interrupt level to 10.

module one_shot_timer_peripheral (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [ostp_pkg::MODE_W-1:0]        req_mode,
   input  logic [ostp_pkg::ADDR_W-1:0]        req_address,
   input  logic [ostp_pkg::DATA_W-1:0]        req_write_data,
   input  logic [ostp_pkg::MASK_W-1:0]        req_write_strobe,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_is_bus_response,
   output logic [ostp_pkg::DATA_W-1:0]        rsp_read_data,
   output logic [ostp_pkg::IRQ_W-1:0]         rsp_interrupt_out,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ostp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ostp_pkg::DATA_W-1:0]        csr_write_data
);

   logic              req_accept;
   ostp_pkg::rsp_type core_rsp;
   ostp_pkg::rsp_type buf_rsp;

   assign csr_ready  = 1'b1;
   assign req_accept = req_valid & ~req_stall;

   // Timer state and request handling
   ostp_core u_core (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_accept       (req_accept),
      .req_mode         (req_mode),
      .req_address      (req_address),
      .req_write_data   (req_write_data),
      .req_write_strobe (req_write_strobe),
      .rsp_data         (core_rsp)
   );

   // Response register with skid stage
   ostp_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_data   (core_rsp),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (buf_rsp)
   );

   assign rsp_is_bus_response = buf_rsp.is_bus_response;
   assign rsp_read_data       = buf_rsp.read_data;
   assign rsp_interrupt_out   = buf_rsp.interrupt_out;

endmodule
